// ===== rtl/core/fir_pkg.sv =====
package fir_pkg;

  localparam int TAPS       = 1024;
  localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FILL_W     = $clog2(TAPS + 1);
  localparam int IDX_W      = 10;
  localparam int SAMPLE_W   = 32;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 32;
  localparam int PROD_W     = 64;
  localparam int ACC_W      = 64;
  localparam int COEF_SHIFT = 30;

  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_COEF   = 1'b1;

  localparam logic signed [ACC_W-1:0] SAT_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [ACC_W-1:0] SAT_MIN = 64'shffff_ffff_8000_0000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } fir_state_t;

  typedef struct packed {
    logic load_sample;
    logic load_coef;
    logic issue;
    logic load_out;
  } fir_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } fir_status_t;

endpackage

// ===== rtl/core/fir_ram.sv =====
module fir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/fir_ctrl.sv =====
module fir_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tuser,
  output logic                 s_tready,
  input  fir_pkg::fir_status_t status,
  output fir_pkg::fir_cmd_t    cmd
);
  import fir_pkg::*;

  fir_state_t state;
  fir_state_t state_next;
  logic       xfer;

  assign xfer = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid && s_tuser == MODE_SAMPLE) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready         = 1'b0;
    cmd.load_sample  = 1'b0;
    cmd.load_coef    = 1'b0;
    cmd.issue        = 1'b0;
    cmd.load_out     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready        = 1'b1;
        cmd.load_sample = xfer && s_tuser == MODE_SAMPLE;
        cmd.load_coef   = xfer && s_tuser == MODE_COEF;
      end
      ST_RUN:   cmd.issue    = 1'b1;
      ST_DRAIN: cmd.issue    = 1'b0;
      ST_DONE:  cmd.load_out = status.out_free;
      default:  s_tready     = 1'b0;
    endcase
  end

endmodule

// ===== rtl/core/fir_dp.sv =====
module fir_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  fir_pkg::fir_cmd_t                cmd,
  output fir_pkg::fir_status_t             status,
  input  logic [fir_pkg::S_TDATA_W-1:0]    s_tdata,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [fir_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                             m_tuser
);
  import fir_pkg::*;

  logic [IDX_W-1:0]           coef_index;
  logic signed [SAMPLE_W-1:0] data_word;
  logic [31:0]                idx_ext;
  logic                       coef_we;

  logic [TAP_W-1:0]  ptr;
  logic [TAP_W-1:0]  ptr_next;
  logic [FILL_W-1:0] fill;
  logic [TAP_W-1:0]  tap_cnt;
  logic [TAP_W-1:0]  hist_rd;

  logic [SAMPLE_W-1:0] hist_q;
  logic [SAMPLE_W-1:0] coef_q;

  logic                       s1_valid;
  logic                       s1_keep;
  logic                       s2_valid;
  logic signed [SAMPLE_W-1:0] hist_op;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   prod_sh;
  logic signed [ACC_W-1:0]    acc;

  logic                       out_valid;
  logic [M_TDATA_W-1:0]       out_data;
  logic                       out_sat;

  assign coef_index = s_tdata[IDX_W-1:0];
  assign data_word  = s_tdata[IDX_W +: SAMPLE_W];
  assign idx_ext    = 32'(coef_index);
  // drop writes to taps that do not exist
  assign coef_we    = cmd.load_coef && (idx_ext < 32'(TAPS));

  assign ptr_next = (ptr == '0) ? TAP_W'(TAPS - 1) : ptr - 1'b1;

  fir_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_hist (
    .clk   (clk),
    .we    (cmd.load_sample),
    .waddr (ptr_next),
    .wdata (data_word),
    .raddr (hist_rd),
    .rdata (hist_q)
  );

  fir_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_coef (
    .clk   (clk),
    .we    (coef_we),
    .waddr (idx_ext[TAP_W-1:0]),
    .wdata (data_word),
    .raddr (tap_cnt),
    .rdata (coef_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr  <= '0;
      fill <= '0;
    end else if (cmd.load_sample) begin
      ptr <= ptr_next;
      if (fill != FILL_W'(TAPS)) begin
        fill <= fill + 1'b1;
      end
    end
  end

  // walk taps: coefficient k against the sample k steps back
  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      tap_cnt <= '0;
      hist_rd <= ptr_next;
    end else if (cmd.issue) begin
      tap_cnt <= tap_cnt + 1'b1;
      hist_rd <= (hist_rd == TAP_W'(TAPS - 1)) ? '0 : hist_rd + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
    end
  end

  // history slots never written since reset read as zero
  always_ff @(posedge clk) begin
    s1_keep <= FILL_W'(tap_cnt) < fill;
  end

  assign hist_op = s1_keep ? $signed(hist_q) : '0;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(hist_op) * PROD_W'($signed(coef_q));
  end

  assign prod_sh = prod >>> COEF_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.load_sample) begin
      acc <= '0;
    end else if (s2_valid) begin
      acc <= acc + prod_sh;
    end
  end

  assign status.last_tap  = tap_cnt == TAP_W'(TAPS - 1);
  assign status.pipe_busy = s1_valid || s2_valid;
  assign status.out_free  = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // clip to the int32 range
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (acc > SAT_MAX) begin
        out_data <= SAT_MAX[M_TDATA_W-1:0];
        out_sat  <= 1'b1;
      end else if (acc < SAT_MIN) begin
        out_data <= SAT_MIN[M_TDATA_W-1:0];
        out_sat  <= 1'b1;
      end else begin
        out_data <= acc[M_TDATA_W-1:0];
        out_sat  <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign m_tuser  = out_sat;

endmodule

// ===== rtl/core/fir_filter_q30_taps.sv =====
// FIR filter, Q1.31 samples against Q2.30 coefficients, 1024 taps.
// Slave stream: s_tuser selects the kind of item. A coefficient item
// (s_tuser = 1) writes one tap of the coefficient memory and gives no
// output; it leaves s_tready high. A sample item (s_tuser = 0)
// enters the history line and starts one filter pass.
// A pass runs one multiply-accumulate per tap per cycle through a single
// registered multiplier, fed from the history and coefficient RAMs, so
// a sample holds s_tready low until its result is loaded into the output
// register; the next transfer can follow once s_tready is high again.
// Output is sum of (sample * coef) >>> 30 over all taps, saturated to
// int32, with m_tuser flagging a clipped result.
// The output register holds a result until the receiver takes it; a new
// item is accepted meanwhile, and a pass only waits at its end if the
// previous result is still held.
// Reset empties the history (unwritten slots count as zero), returns to
// idle and drops m_tvalid. Load every coefficient before filtering.
module fir_filter_q30_taps (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [fir_pkg::S_TDATA_W-1:0]     s_tdata,  // coef_index[9:0], data_word[41:10]
  input  logic                              s_tuser,  // mode
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [fir_pkg::M_TDATA_W-1:0]     m_tdata,  // filtered_sample[31:0]
  output logic                              m_tuser   // saturated
);
  import fir_pkg::*;

  fir_cmd_t    cmd;
  fir_status_t status;

  fir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  fir_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .status   (status),
    .s_tdata  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== rtl/core/fir_chk.sv =====
module fir_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [fir_pkg::S_TDATA_W-1:0] s_tdata,
  input logic                          s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fir_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser
);
  import fir_pkg::*;

  a_rst_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output changed");

  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == MODE_SAMPLE |=> !s_tready)
    else $error("ready held through a filter pass");

  a_coef_fast: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == MODE_COEF |=> s_tready)
    else $error("coefficient transfer stalled the input");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000)
    else $error("saturation flag without a clipped value");

endmodule

bind fir_filter_q30_taps fir_chk u_chk (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  import fir_pkg::*;

  // Slowest correct run: every item after the first full coefficient load a
  // sample with long output stalls, that load at a high sender idle rate,
  // one long hold and the tail.
  localparam int LIMIT = 4 * (600 * (TAPS + 5 + 64) + TAPS * 8 + 5 * TAPS);

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sat;
  } filt_out_t;

  class fir_scoreboard;
    logic signed [SAMPLE_W-1:0] history [TAPS];
    logic signed [SAMPLE_W-1:0] coefs [TAPS];
    int unsigned newest;
    filt_out_t   pending_q[$];
    int          mismatches;
    int          outputs_seen;
    int          samples_in;
    int          coefs_in;
    int          clipped;

    function new();
      foreach (history[i]) begin
        history[i] = '0;
        coefs[i]   = '0;
      end
      newest       = 0;
      mismatches   = 0;
      outputs_seen = 0;
      samples_in   = 0;
      coefs_in     = 0;
      clipped      = 0;
    endfunction

    // Update the filter state with one accepted transfer; queue the output it causes.
    function void note_item(logic mode, logic [IDX_W-1:0] idx,
                            logic signed [SAMPLE_W-1:0] word);
      logic signed [ACC_W-1:0]  acc;
      logic signed [PROD_W-1:0] prod;
      filt_out_t                res;
      if (mode == MODE_COEF) begin
        if (int'(idx) < TAPS) begin
          coefs[idx] = word;
        end
        coefs_in++;
        return;
      end
      samples_in++;
      newest = (newest == 0) ? TAPS - 1 : newest - 1;
      history[newest] = word;
      acc = '0;
      for (int k = 0; k < TAPS; k++) begin
        // both operands signed, so they widen to 64 bits before the multiply
        prod = history[(newest + k) % TAPS] * coefs[k];
        acc  = acc + (prod >>> COEF_SHIFT);
      end
      if (acc > SAT_MAX) begin
        res.sample = SAT_MAX[SAMPLE_W-1:0];
        res.sat    = 1'b1;
      end else if (acc < SAT_MIN) begin
        res.sample = SAT_MIN[SAMPLE_W-1:0];
        res.sat    = 1'b1;
      end else begin
        res.sample = acc[SAMPLE_W-1:0];
        res.sat    = 1'b0;
      end
      if (res.sat) begin
        clipped++;
      end
      pending_q.push_back(res);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [SAMPLE_W-1:0] got, logic got_sat);
      filt_out_t want;
      outputs_seen++;
      if (pending_q.size() == 0) begin
        report_mismatch($sformatf("output %h sat %b with nothing pending", got, got_sat));
        return;
      end
      want = pending_q.pop_front();
      if (got !== want.sample) begin
        report_mismatch($sformatf("output %0d: sample %h, want %h",
                                  outputs_seen, got, want.sample));
      end
      if (got_sat !== want.sat) begin
        report_mismatch($sformatf("output %0d: saturated %b, want %b",
                                  outputs_seen, got_sat, want.sat));
      end
    endtask

    function int outstanding();
      return pending_q.size();
    endfunction
  endclass

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tuser  = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;

  int          send_idle_pct = 19;
  int          recv_idle_pct = 73;
  int          hold_len      = 0;
  int unsigned cycles        = 0;

  fir_scoreboard sb = new();

  fir_filter_q30_taps u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Output side: random back-pressure, or a long hold when one is requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        m_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Signals are stable mid-cycle, so a handshake seen here completes at the next edge.
  initial begin
    forever begin
      @(negedge clk);
      if (!rst && m_tvalid && m_tready) begin
        sb.check_result(m_tdata, m_tuser);
      end
    end
  end

  task automatic send_item(logic mode, logic [IDX_W-1:0] idx,
                           logic signed [SAMPLE_W-1:0] word);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= S_TDATA_W'({word, idx});
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    sb.note_item(mode, idx, word);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  // Signed random value of about +/- 2**mag_bits.
  function automatic logic signed [SAMPLE_W-1:0] rand_coef(int mag_bits);
    logic signed [SAMPLE_W-1:0] raw;
    raw = $urandom;
    if (mag_bits >= SAMPLE_W - 1) begin
      return raw;
    end
    return raw >>> (SAMPLE_W - 1 - mag_bits);
  endfunction

  task automatic send_sample(logic signed [SAMPLE_W-1:0] word);
    send_item(MODE_SAMPLE, IDX_W'($urandom), word);
  endtask

  task automatic run_random(int n, int mag_bits, bit long_hold);
    int choice;
    logic signed [SAMPLE_W-1:0] extremes [4];
    extremes = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sh1};
    for (int i = 0; i < n; i++) begin
      if (long_hold && i == n / 4) begin
        hold_len = 4 * TAPS;
      end
      choice = $urandom_range(99);
      if (choice < 35) begin
        // mostly in-scale taps; the odd full-range one pushes sums into clipping
        send_item(MODE_COEF, IDX_W'($urandom),
                  ($urandom_range(7) == 0) ? rand_coef(SAMPLE_W - 1) : rand_coef(mag_bits));
      end else if (choice < 41) begin
        send_sample(extremes[$urandom_range(3)]);
      end else begin
        send_sample($urandom);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Every tap must hold a value before the first sample goes in.
    for (int t = 0; t < TAPS; t++) begin
      send_item(MODE_COEF, IDX_W'(t), '0);
    end

    // Unity gain on tap 0: full-scale, zero and plus/minus one cases.
    send_item(MODE_COEF, IDX_W'(0), 32'sh4000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0);
    send_sample(-32'sh1);
    send_sample(32'sh1);
    // Extreme coefficients at both ends of the tap range: clip in both directions.
    send_item(MODE_COEF, IDX_W'(TAPS - 1), 32'sh7fff_ffff);
    send_item(MODE_COEF, IDX_W'(0), 32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);
    send_item(MODE_COEF, IDX_W'(1), 32'sh8000_0000);
    send_sample(32'sh8000_0000);
    send_sample(32'sh7fff_ffff);
    // Tiny coefficient: the shift floors each product, so a sample of -1 gives -1.
    send_item(MODE_COEF, IDX_W'(0), 32'sh1);
    send_item(MODE_COEF, IDX_W'(1), 32'sh0);
    send_sample(-32'sh1);
    send_sample(32'sh7fff_ffff);
    send_sample(32'sh8000_0000);

    // Hold the sender until every output has been taken.
    wait_drained();

    run_random(190, 12, 1'b0);
    wait_drained();

    send_idle_pct = 73;
    recv_idle_pct = 19;
    run_random(190, 20, 1'b0);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(190, 28, 1'b1);

    wait_drained();
    repeat (TAPS + 10) @(posedge clk);

    $display("run: %0d samples, %0d coefficient writes, %0d outputs checked",
             sb.samples_in, sb.coefs_in, sb.outputs_seen);
    $display("run: %0d clipped outputs, random taps at scales 2^12/2^20/2^28, long output hold",
             sb.clipped);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
